// ----- rtl/indexed_linked_list_engine_core_assert.svh -----
// assertion macros for the list engine rtl
// no dependencies; included by idxll_dp, which carries concurrent checks
`ifndef INDEXED_LINKED_LIST_ENGINE_CORE_ASSERT_SVH
`define INDEXED_LINKED_LIST_ENGINE_CORE_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define ILL_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("list engine check failed");

// next-cycle implication, disabled while in reset
`define ILL_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("list engine check failed");

`endif

// ----- rtl/idxll_pkg.sv -----
// shared types for the indexed linked list engine
// no dependencies; used by controller, datapath and top level
`default_nettype none

package idxll_pkg;

  typedef enum logic [2:0] {
    REQ_READ   = 3'd0,
    REQ_WRITE  = 3'd1,
    REQ_INSERT = 3'd2,
    REQ_APPEND = 3'd3,
    REQ_REMOVE = 3'd4,
    REQ_SEARCH = 3'd5
  } req_e;

  typedef enum logic [1:0] {
    STS_OK        = 2'd0,
    STS_RANGE     = 2'd1,
    STS_FULL      = 2'd2,
    STS_NOT_FOUND = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_DECODE, S_ALLOC, S_ALLOC2, S_WALK, S_RDWR, S_INS_A,
    S_INS_B, S_REM0, S_REM_A, S_REM_B, S_REM_C, S_SRCH, S_FINISH
  } state_e;

  typedef enum logic [1:0] {TGT_POS, TGT_POS_M1, TGT_ZERO} tgt_e;
  typedef enum logic [1:0] {WA_SLOT, WA_CUR, WA_PREV} waddr_e;
  typedef enum logic [1:0] {WD_HEAD, WD_RD, WD_SLOT, WD_FREE} wdata_e;
  typedef enum logic {HD_SLOT, HD_RD} head_e;

  typedef struct packed {
    logic    load;
    logic    init_wr;
    logic    set_pos_count;
    logic    walk_setup;
    tgt_e    tgt;
    logic    walk_step;
    logic    cnt_dec;
    logic    cnt_inc;
    logic    alloc_rd;
    logic    free_from_rd;
    logic    free_to_cur;
    logic    link_we;
    waddr_e  waddr;
    wdata_e  wdata;
    logic    head_we;
    head_e   head_src;
    logic    count_inc;
    logic    count_dec;
    logic    prev_save;
    logic    elem_wr_cur;
    logic    res_we;
    status_e res_status;
    logic    res_data;
    logic    res_found;
    logic    out_load;
  } cmd_t;

  typedef struct packed {
    req_e req;
    logic pos_lt_count;
    logic pos_le_count;
    logic full;
    logic pos_zero;
    logic cnt_zero;
    logic search_done;
    logic match;
    logic init_last;
  } sts_t;

endpackage

`default_nettype wire

// ----- rtl/idxll_ctrl.sv -----
// sequencing state machine for the list engine
// depends on idxll_pkg; drives commands into idxll_dp
`default_nettype none

module idxll_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             s_axis_tvalid,
  output logic                  s_axis_tready,
  output logic                  m_axis_tvalid,
  input  wire logic             m_axis_tready,
  input  wire idxll_pkg::sts_t  sts_i,
  output idxll_pkg::cmd_t       cmd_o
);

  idxll_pkg::state_e state_q, state_d;
  logic              oval_q, oval_d;
  logic              out_free;

  assign out_free      = !oval_q || m_axis_tready;
  assign m_axis_tvalid = oval_q;
  assign s_axis_tready = (state_q == idxll_pkg::S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= idxll_pkg::S_INIT;
      oval_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      oval_q  <= oval_d;
    end
  end

  always_comb begin
    cmd_o            = '0;
    cmd_o.tgt        = idxll_pkg::TGT_POS;
    cmd_o.waddr      = idxll_pkg::WA_SLOT;
    cmd_o.wdata      = idxll_pkg::WD_HEAD;
    cmd_o.head_src   = idxll_pkg::HD_SLOT;
    cmd_o.res_status = idxll_pkg::STS_OK;
    state_d          = state_q;
    oval_d           = oval_q && !m_axis_tready;

    case (state_q)
      idxll_pkg::S_INIT: begin
        cmd_o.init_wr = 1'b1;
        if (sts_i.init_last) state_d = idxll_pkg::S_IDLE;
      end
      idxll_pkg::S_IDLE: begin
        if (s_axis_tvalid) begin
          cmd_o.load = 1'b1;
          state_d    = idxll_pkg::S_DECODE;
        end
      end
      idxll_pkg::S_DECODE: begin
        case (sts_i.req)
          idxll_pkg::REQ_READ, idxll_pkg::REQ_WRITE: begin
            if (!sts_i.pos_lt_count) begin
              cmd_o.res_we     = 1'b1;
              cmd_o.res_status = idxll_pkg::STS_RANGE;
              state_d          = idxll_pkg::S_FINISH;
            end else begin
              cmd_o.walk_setup = 1'b1;
              cmd_o.tgt        = idxll_pkg::TGT_POS;
              state_d          = idxll_pkg::S_WALK;
            end
          end
          idxll_pkg::REQ_INSERT: begin
            if (!sts_i.pos_le_count) begin
              cmd_o.res_we     = 1'b1;
              cmd_o.res_status = idxll_pkg::STS_RANGE;
              state_d          = idxll_pkg::S_FINISH;
            end else if (sts_i.full) begin
              cmd_o.res_we     = 1'b1;
              cmd_o.res_status = idxll_pkg::STS_FULL;
              state_d          = idxll_pkg::S_FINISH;
            end else begin
              state_d = idxll_pkg::S_ALLOC;
            end
          end
          idxll_pkg::REQ_APPEND: begin
            if (sts_i.full) begin
              cmd_o.res_we     = 1'b1;
              cmd_o.res_status = idxll_pkg::STS_FULL;
              state_d          = idxll_pkg::S_FINISH;
            end else begin
              cmd_o.set_pos_count = 1'b1;
              state_d             = idxll_pkg::S_ALLOC;
            end
          end
          idxll_pkg::REQ_REMOVE: begin
            if (!sts_i.pos_lt_count) begin
              cmd_o.res_we     = 1'b1;
              cmd_o.res_status = idxll_pkg::STS_RANGE;
              state_d          = idxll_pkg::S_FINISH;
            end else begin
              cmd_o.walk_setup = 1'b1;
              cmd_o.tgt        = sts_i.pos_zero ? idxll_pkg::TGT_POS : idxll_pkg::TGT_POS_M1;
              state_d          = idxll_pkg::S_WALK;
            end
          end
          idxll_pkg::REQ_SEARCH: begin
            cmd_o.walk_setup = 1'b1;
            cmd_o.tgt        = idxll_pkg::TGT_ZERO;
            state_d          = idxll_pkg::S_SRCH;
          end
          default: begin
            cmd_o.res_we = 1'b1;
            state_d      = idxll_pkg::S_FINISH;
          end
        endcase
      end
      idxll_pkg::S_ALLOC: begin
        cmd_o.alloc_rd = 1'b1;
        state_d        = idxll_pkg::S_ALLOC2;
      end
      idxll_pkg::S_ALLOC2: begin
        cmd_o.free_from_rd = 1'b1;
        if (sts_i.pos_zero) begin
          cmd_o.link_we   = 1'b1;
          cmd_o.waddr     = idxll_pkg::WA_SLOT;
          cmd_o.wdata     = idxll_pkg::WD_HEAD;
          cmd_o.head_we   = 1'b1;
          cmd_o.head_src  = idxll_pkg::HD_SLOT;
          cmd_o.count_inc = 1'b1;
          cmd_o.res_we    = 1'b1;
          state_d         = idxll_pkg::S_FINISH;
        end else begin
          cmd_o.walk_setup = 1'b1;
          cmd_o.tgt        = idxll_pkg::TGT_POS_M1;
          state_d          = idxll_pkg::S_WALK;
        end
      end
      idxll_pkg::S_WALK: begin
        cmd_o.walk_step = 1'b1;
        if (!sts_i.cnt_zero) begin
          cmd_o.cnt_dec = 1'b1;
        end else begin
          case (sts_i.req)
            idxll_pkg::REQ_READ, idxll_pkg::REQ_WRITE: state_d = idxll_pkg::S_RDWR;
            idxll_pkg::REQ_INSERT, idxll_pkg::REQ_APPEND: state_d = idxll_pkg::S_INS_A;
            default: state_d = sts_i.pos_zero ? idxll_pkg::S_REM0 : idxll_pkg::S_REM_A;
          endcase
        end
      end
      idxll_pkg::S_RDWR: begin
        cmd_o.elem_wr_cur = (sts_i.req == idxll_pkg::REQ_WRITE);
        cmd_o.res_we      = 1'b1;
        cmd_o.res_data    = 1'b1;
        state_d           = idxll_pkg::S_FINISH;
      end
      idxll_pkg::S_INS_A: begin
        cmd_o.link_we = 1'b1;
        cmd_o.waddr   = idxll_pkg::WA_SLOT;
        cmd_o.wdata   = idxll_pkg::WD_RD;
        state_d       = idxll_pkg::S_INS_B;
      end
      idxll_pkg::S_INS_B: begin
        cmd_o.link_we   = 1'b1;
        cmd_o.waddr     = idxll_pkg::WA_CUR;
        cmd_o.wdata     = idxll_pkg::WD_SLOT;
        cmd_o.count_inc = 1'b1;
        cmd_o.res_we    = 1'b1;
        state_d         = idxll_pkg::S_FINISH;
      end
      idxll_pkg::S_REM0: begin
        cmd_o.head_we     = 1'b1;
        cmd_o.head_src    = idxll_pkg::HD_RD;
        cmd_o.link_we     = 1'b1;
        cmd_o.waddr       = idxll_pkg::WA_CUR;
        cmd_o.wdata       = idxll_pkg::WD_FREE;
        cmd_o.free_to_cur = 1'b1;
        cmd_o.count_dec   = 1'b1;
        cmd_o.res_we      = 1'b1;
        cmd_o.res_data    = 1'b1;
        state_d           = idxll_pkg::S_FINISH;
      end
      idxll_pkg::S_REM_A: begin
        cmd_o.prev_save = 1'b1;
        cmd_o.walk_step = 1'b1;
        state_d         = idxll_pkg::S_REM_B;
      end
      idxll_pkg::S_REM_B: begin
        cmd_o.link_we = 1'b1;
        cmd_o.waddr   = idxll_pkg::WA_PREV;
        cmd_o.wdata   = idxll_pkg::WD_RD;
        state_d       = idxll_pkg::S_REM_C;
      end
      idxll_pkg::S_REM_C: begin
        cmd_o.link_we     = 1'b1;
        cmd_o.waddr       = idxll_pkg::WA_CUR;
        cmd_o.wdata       = idxll_pkg::WD_FREE;
        cmd_o.free_to_cur = 1'b1;
        cmd_o.count_dec   = 1'b1;
        cmd_o.res_we      = 1'b1;
        cmd_o.res_data    = 1'b1;
        state_d           = idxll_pkg::S_FINISH;
      end
      idxll_pkg::S_SRCH: begin
        if (sts_i.match) begin
          cmd_o.res_we    = 1'b1;
          cmd_o.res_found = 1'b1;
          state_d         = idxll_pkg::S_FINISH;
        end else if (sts_i.search_done) begin
          cmd_o.res_we     = 1'b1;
          cmd_o.res_status = idxll_pkg::STS_NOT_FOUND;
          state_d          = idxll_pkg::S_FINISH;
        end else begin
          cmd_o.walk_step = 1'b1;
          cmd_o.cnt_inc   = 1'b1;
        end
      end
      idxll_pkg::S_FINISH: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          oval_d         = 1'b1;
          state_d        = idxll_pkg::S_IDLE;
        end
      end
      default: state_d = idxll_pkg::S_IDLE;
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/idxll_dp.sv -----
// slot memories, list pointers, walk counter and result registers
// depends on idxll_pkg and the assertion header; driven by idxll_ctrl
`default_nettype none

`include "indexed_linked_list_engine_core_assert.svh"

module idxll_dp #(
  parameter int CAPACITY   = 32,
  parameter int ELEM_WIDTH = 32
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic [2:0]        req_type_i,
  input  wire logic [4:0]        position_i,
  input  wire logic [31:0]       value_i,
  input  wire idxll_pkg::cmd_t   cmd_i,
  output idxll_pkg::sts_t        sts_o,
  output logic [1:0]             status_o,
  output logic [31:0]            data_out_o,
  output logic [4:0]             found_position_o,
  output logic [5:0]             item_count_o
);

  localparam int PW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int LW   = $clog2(CAPACITY + 1);
  localparam int CMPW = (LW > 5) ? LW : 5;
  localparam logic [LW-1:0] NULL_LINK = LW'(CAPACITY);
  localparam logic [LW-1:0] LAST_SLOT = LW'(CAPACITY - 1);

  logic [LW-1:0]         link_mem [CAPACITY];
  logic [ELEM_WIDTH-1:0] elem_mem [CAPACITY];

  logic [LW-1:0] head_q, head_d, free_q, free_d, count_q, count_d;
  logic [LW-1:0] cur_q, cur_d, cnt_q, cnt_d;
  logic          pend_q, pend_d, sv_q, sv_d;
  logic [LW-1:0] prev_q, slot_q, link_rd_q;
  logic [ELEM_WIDTH-1:0] elem_rd_q, val_q;
  logic [2:0]    req_q;
  logic [CMPW-1:0] pos_q;

  logic [1:0]  res_status_q, out_status_q;
  logic [31:0] res_data_q, out_data_q;
  logic [4:0]  res_found_q, out_found_q;
  logic [5:0]  res_count_q, out_count_q;

  logic [LW-1:0] eff, lk_raddr, lk_waddr, lk_wdata;
  logic          lk_we, lk_re;
  logic [LW-1:0] el_waddr;
  logic          el_we;
  logic [63:0]   val_ext, rd_ext;

  assign eff     = pend_q ? link_rd_q : cur_q;
  assign val_ext = 64'($signed(value_i));
  assign rd_ext  = 64'($signed(elem_rd_q));

  // link and element memory port selection
  always_comb begin
    lk_re    = cmd_i.walk_step || cmd_i.alloc_rd;
    lk_raddr = cmd_i.alloc_rd ? free_q : eff;
    lk_we    = cmd_i.init_wr || cmd_i.link_we;
    lk_waddr = cnt_q;
    lk_wdata = (cnt_q == LAST_SLOT) ? NULL_LINK : cnt_q + LW'(1);
    if (!cmd_i.init_wr) begin
      case (cmd_i.waddr)
        idxll_pkg::WA_SLOT: lk_waddr = slot_q;
        idxll_pkg::WA_CUR:  lk_waddr = cur_q;
        idxll_pkg::WA_PREV: lk_waddr = prev_q;
        default:            lk_waddr = slot_q;
      endcase
      case (cmd_i.wdata)
        idxll_pkg::WD_HEAD: lk_wdata = head_q;
        idxll_pkg::WD_RD:   lk_wdata = link_rd_q;
        idxll_pkg::WD_SLOT: lk_wdata = slot_q;
        idxll_pkg::WD_FREE: lk_wdata = free_q;
        default:            lk_wdata = head_q;
      endcase
    end
    el_we    = cmd_i.alloc_rd || cmd_i.elem_wr_cur;
    el_waddr = cmd_i.alloc_rd ? free_q : cur_q;
  end

  always_ff @(posedge clk_i) begin
    if (lk_we) link_mem[lk_waddr[PW-1:0]] <= lk_wdata;
    if (lk_re) link_rd_q <= link_mem[lk_raddr[PW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (el_we) elem_mem[el_waddr[PW-1:0]] <= val_q;
    if (cmd_i.walk_step) elem_rd_q <= elem_mem[eff[PW-1:0]];
  end

  // pointer and counter updates
  always_comb begin
    head_d  = head_q;
    free_d  = free_q;
    count_d = count_q;
    cur_d   = cur_q;
    pend_d  = pend_q;
    sv_d    = sv_q;
    cnt_d   = cnt_q;
    if (cmd_i.init_wr) cnt_d = cnt_q + LW'(1);
    if (cmd_i.walk_setup) begin
      cur_d  = head_q;
      pend_d = 1'b0;
      sv_d   = 1'b0;
      case (cmd_i.tgt)
        idxll_pkg::TGT_POS:    cnt_d = LW'(pos_q);
        idxll_pkg::TGT_POS_M1: cnt_d = LW'(pos_q - CMPW'(1));
        idxll_pkg::TGT_ZERO:   cnt_d = {LW{1'b0}};
        default:               cnt_d = {LW{1'b0}};
      endcase
    end
    if (cmd_i.walk_step) begin
      cur_d  = eff;
      pend_d = 1'b1;
      sv_d   = 1'b1;
    end
    if (cmd_i.cnt_dec) cnt_d = cnt_q - LW'(1);
    if (cmd_i.cnt_inc) cnt_d = cnt_q + LW'(1);
    if (cmd_i.free_from_rd) free_d = link_rd_q;
    if (cmd_i.free_to_cur)  free_d = cur_q;
    if (cmd_i.head_we) head_d = (cmd_i.head_src == idxll_pkg::HD_RD) ? link_rd_q : slot_q;
    if (cmd_i.count_inc) count_d = count_q + LW'(1);
    if (cmd_i.count_dec) count_d = count_q - LW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= NULL_LINK;
      free_q  <= {LW{1'b0}};
      count_q <= {LW{1'b0}};
      cur_q   <= {LW{1'b0}};
      pend_q  <= 1'b0;
      sv_q    <= 1'b0;
      cnt_q   <= {LW{1'b0}};
    end else begin
      head_q  <= head_d;
      free_q  <= free_d;
      count_q <= count_d;
      cur_q   <= cur_d;
      pend_q  <= pend_d;
      sv_q    <= sv_d;
      cnt_q   <= cnt_d;
    end
  end

  // request, slot and result payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q <= req_type_i;
      pos_q <= CMPW'(position_i);
      val_q <= val_ext[ELEM_WIDTH-1:0];
    end
    if (cmd_i.set_pos_count) pos_q <= CMPW'(count_q);
    if (cmd_i.alloc_rd)      slot_q <= free_q;
    if (cmd_i.prev_save)     prev_q <= cur_q;
    if (cmd_i.res_we) begin
      res_status_q <= cmd_i.res_status;
      res_data_q   <= cmd_i.res_data ? rd_ext[31:0] : 32'd0;
      res_found_q  <= cmd_i.res_found ? 5'(cnt_q - LW'(1)) : 5'd0;
      res_count_q  <= 6'(count_d);
    end
    if (cmd_i.out_load) begin
      out_status_q <= res_status_q;
      out_data_q   <= res_data_q;
      out_found_q  <= res_found_q;
      out_count_q  <= res_count_q;
    end
  end

  assign status_o         = out_status_q;
  assign data_out_o       = out_data_q;
  assign found_position_o = out_found_q;
  assign item_count_o     = out_count_q;

  always_comb begin
    sts_o.req          = idxll_pkg::req_e'(req_q);
    sts_o.pos_lt_count = pos_q < CMPW'(count_q);
    sts_o.pos_le_count = pos_q <= CMPW'(count_q);
    sts_o.full         = (count_q == NULL_LINK);
    sts_o.pos_zero     = (pos_q == {CMPW{1'b0}});
    sts_o.cnt_zero     = (cnt_q == {LW{1'b0}});
    sts_o.search_done  = (cnt_q == count_q);
    sts_o.match        = sv_q && (elem_rd_q == val_q);
    sts_o.init_last    = (cnt_q == LAST_SLOT);
  end

  `ILL_ASSERT_IMP(a_count_max, clk_i, rst_ni, 1'b1, count_q <= NULL_LINK)
  `ILL_ASSERT_IMP(a_empty_head, clk_i, rst_ni, count_q == {LW{1'b0}}, head_q == NULL_LINK)
  `ILL_ASSERT_IMP(a_head_empty, clk_i, rst_ni, head_q == NULL_LINK, count_q == {LW{1'b0}})
  `ILL_ASSERT_NXT(a_count_step, clk_i, rst_ni, 1'b1, (count_q == $past(count_q)) || (count_q == $past(count_q) + LW'(1)) || (count_q == $past(count_q) - LW'(1)))

endmodule

`default_nettype wire

// ----- rtl/indexed_linked_list_engine_core.sv -----
// top level of the indexed linked list engine: stream ports, controller, datapath
// depends on idxll_pkg, idxll_ctrl and idxll_dp
//
// a positional list of up to CAPACITY elements held as a singly linked chain
// in a slot memory, with unused slots on a free chain. each input word is one
// request (read, overwrite, insert, append, remove, search) and yields exactly
// one output word with status, old or read element, found position and count.
// after reset the block runs a pass that chains the link memory and holds
// s_axis_tready low until it is done. the block takes one request at a time
// and accepts no new input word until the last one is finished. the walk
// follows one link per cycle through the registered link memory read port.
// a finished word waits in an output register while the next request is
// taken; a result that is still blocked by a stalled receiver holds the block
// in its finish step.
`default_nettype none

module indexed_linked_list_engine_core #(
  parameter int CAPACITY   = 32,
  parameter int ELEM_WIDTH = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // [2:0] req_type, [7:3] position, [39:8] value
  input  wire logic [39:0] s_axis_tdata,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [1:0] status, [33:2] data_out, [38:34] found_position, [44:39] item_count
  output logic [47:0]      m_axis_tdata
);

  idxll_pkg::cmd_t cmd;
  idxll_pkg::sts_t sts;

  logic [1:0]  status;
  logic [31:0] data_out;
  logic [4:0]  found_position;
  logic [5:0]  item_count;

  // sequencing: decode, walk, link repair and result handoff
  idxll_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .sts_i         (sts),
    .cmd_o         (cmd)
  );

  // slot memories, pointers and result registers
  idxll_dp #(
    .CAPACITY   (CAPACITY),
    .ELEM_WIDTH (ELEM_WIDTH)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .req_type_i       (s_axis_tdata[2:0]),
    .position_i       (s_axis_tdata[7:3]),
    .value_i          (s_axis_tdata[39:8]),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .status_o         (status),
    .data_out_o       (data_out),
    .found_position_o (found_position),
    .item_count_o     (item_count)
  );

  // output word, padded to whole bytes
  assign m_axis_tdata = {3'b000, item_count, found_position, data_out, status};

endmodule

`default_nettype wire

// ----- verif/indexed_linked_list_engine_core_tb.sv -----
// self-checking testbench for indexed_linked_list_engine_core
// depends on idxll_pkg and the engine rtl; directed table, a fill to capacity, then random requests
`timescale 1ns / 1ps

module indexed_linked_list_engine_core_tb;

  localparam int CAP = 32;
  localparam int N_RANDOM = 1100;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] data_out;
    logic [4:0]  found_pos;
    logic [5:0]  item_count;
  } resp_t;

  typedef struct {
    logic [2:0]  req;
    logic [4:0]  pos;
    logic [31:0] value;
    bit          has_fixed;
    resp_t       fixed;
  } row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  // [2:0] req_type, [7:3] position, [39:8] value
  logic [39:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // [1:0] status, [33:2] data_out, [38:34] found_position, [44:39] item_count
  logic [47:0] m_axis_tdata;

  always #5 clk_i = ~clk_i;

  indexed_linked_list_engine_core uut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  // shadow list: positions map straight onto a queue of elements
  logic [31:0] shadow_list[$];
  resp_t       pending_resp[$];
  int          err_count = 0;
  bit          hold_off = 1'b0;
  bit          stim_done = 1'b0;

  task automatic report_mismatch(input string what, input logic [47:0] got,
                                 input logic [47:0] want);
    $display("mismatch %s: got %h want %h", what, got, want);
    err_count++;
  endtask

  // response laid out as on m_axis_tdata
  function automatic logic [47:0] to_word(input resp_t r);
    return {3'b000, r.item_count, r.found_pos, r.data_out, r.status};
  endfunction

  // applies one request to the shadow list and returns its response word
  function automatic resp_t list_apply(input logic [2:0] req, input logic [4:0] pos,
                                       input logic [31:0] value);
    resp_t r;
    int    cnt;
    r = '0;
    cnt = shadow_list.size();
    case (req)
      idxll_pkg::REQ_READ, idxll_pkg::REQ_WRITE: begin
        if (pos >= cnt) r.status = idxll_pkg::STS_RANGE;
        else begin
          r.data_out = shadow_list[pos];
          if (req == idxll_pkg::REQ_WRITE) shadow_list[pos] = value;
        end
      end
      idxll_pkg::REQ_INSERT: begin
        if (pos > cnt) r.status = idxll_pkg::STS_RANGE;
        else if (cnt >= CAP) r.status = idxll_pkg::STS_FULL;
        else shadow_list.insert(pos, value);
      end
      idxll_pkg::REQ_APPEND: begin
        if (cnt >= CAP) r.status = idxll_pkg::STS_FULL;
        else shadow_list.push_back(value);
      end
      idxll_pkg::REQ_REMOVE: begin
        if (pos >= cnt) r.status = idxll_pkg::STS_RANGE;
        else begin
          r.data_out = shadow_list[pos];
          shadow_list.delete(pos);
        end
      end
      idxll_pkg::REQ_SEARCH: begin
        r.status = idxll_pkg::STS_NOT_FOUND;
        for (int i = 0; i < cnt; i++) begin
          if (shadow_list[i] == value) begin
            r.status = idxll_pkg::STS_OK;
            r.found_pos = i[4:0];
            break;
          end
        end
      end
      default: ;  // unused codes change nothing
    endcase
    r.item_count = 6'(shadow_list.size());
    return r;
  endfunction

  function automatic resp_t fixed_resp(input idxll_pkg::status_e st,
                                       input logic [31:0] d, input int cnt);
    resp_t r;
    r = '0;
    r.status = st;
    r.data_out = d;
    r.item_count = cnt[5:0];
    return r;
  endfunction

  task automatic send_word(input logic [2:0] req, input logic [4:0] pos,
                           input logic [31:0] value);
    resp_t r;
    repeat ($urandom_range(0, 7) * ($urandom_range(0, 3) != 0)) begin
      @(posedge clk_i);
      s_axis_tvalid <= 1'b0;
    end
    @(posedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {value, pos, req};
    do @(posedge clk_i); while (!s_axis_tready);
    r = list_apply(req, pos, value);
    pending_resp.push_back(r);
    s_axis_tvalid <= 1'b0;
  endtask

  // values drawn half the time from a small pool so searches hit often
  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 7);
      1: return 32'h8000_0000 | $urandom_range(0, 1);
      default: return $urandom;
    endcase
  endfunction

  task automatic send_random();
    logic [2:0] req;
    logic [4:0] pos;
    int         cnt;
    int         k;
    cnt = shadow_list.size();
    k = $urandom_range(0, 99);
    // lean toward growth below twenty entries, toward removal from there on
    if (k < 4) req = 3'($urandom_range(6, 7));
    else if (k < 30) req = (cnt < 20) ? idxll_pkg::REQ_APPEND : idxll_pkg::REQ_REMOVE;
    else if (k < 45) req = idxll_pkg::REQ_INSERT;
    else if (k < 58) req = idxll_pkg::REQ_REMOVE;
    else req = 3'($urandom_range(0, 5));
    if ($urandom_range(0, 9) == 0 || cnt == 0) pos = 5'($urandom);
    else pos = 5'($urandom_range(0, (req == idxll_pkg::REQ_INSERT) ? cnt : cnt - 1));
    if (req == idxll_pkg::REQ_SEARCH && cnt > 0 && $urandom_range(0, 2) != 0)
      send_word(req, pos, shadow_list[$urandom_range(0, cnt - 1)]);
    else send_word(req, pos, pick_value());
  endtask

  // stimulus: directed table, a fill-up under receiver hold-off, then random
  initial begin
    row_t table_rows[$];
    row_t row;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    table_rows = '{
      '{idxll_pkg::REQ_READ,   5'd0,  32'h0,         1,
        fixed_resp(idxll_pkg::STS_RANGE, 32'd0, 0)},
      '{idxll_pkg::REQ_REMOVE, 5'd0,  32'h0,         1,
        fixed_resp(idxll_pkg::STS_RANGE, 32'd0, 0)},
      '{idxll_pkg::REQ_SEARCH, 5'd0,  32'h0,         1,
        fixed_resp(idxll_pkg::STS_NOT_FOUND, 32'd0, 0)},
      '{idxll_pkg::REQ_INSERT, 5'd1,  32'h1,         1,
        fixed_resp(idxll_pkg::STS_RANGE, 32'd0, 0)},
      '{3'd6,                  5'd31, 32'hFFFF_FFFF, 1,
        fixed_resp(idxll_pkg::STS_OK, 32'd0, 0)},
      '{idxll_pkg::REQ_INSERT, 5'd0,  32'h7FFF_FFFF, 1,
        fixed_resp(idxll_pkg::STS_OK, 32'd0, 1)},
      '{idxll_pkg::REQ_APPEND, 5'd31, 32'h8000_0000, 1,
        fixed_resp(idxll_pkg::STS_OK, 32'd0, 2)},
      '{idxll_pkg::REQ_INSERT, 5'd2,  32'hFFFF_FFFF, 0, '0},
      '{idxll_pkg::REQ_INSERT, 5'd1,  32'h0,         0, '0},
      '{idxll_pkg::REQ_READ,   5'd3,  32'h0,         1,
        fixed_resp(idxll_pkg::STS_OK, 32'hFFFF_FFFF, 4)},
      '{idxll_pkg::REQ_READ,   5'd4,  32'h0,         1,
        fixed_resp(idxll_pkg::STS_RANGE, 32'd0, 4)},
      '{idxll_pkg::REQ_WRITE,  5'd0,  32'h5555_AAAA, 1,
        fixed_resp(idxll_pkg::STS_OK, 32'h7FFF_FFFF, 4)},
      '{idxll_pkg::REQ_SEARCH, 5'd0,  32'hFFFF_FFFF, 0, '0},
      '{idxll_pkg::REQ_SEARCH, 5'd0,  32'h1234_5678, 0, '0},
      '{idxll_pkg::REQ_REMOVE, 5'd3,  32'h0,         0, '0},
      '{idxll_pkg::REQ_REMOVE, 5'd0,  32'h0,         0, '0},
      '{idxll_pkg::REQ_REMOVE, 5'd1,  32'h0,         0, '0},
      '{idxll_pkg::REQ_WRITE,  5'd31, 32'h1,         0, '0},
      '{3'd7,                  5'd0,  32'h0,         0, '0}
    };
    foreach (table_rows[i]) begin
      row = table_rows[i];
      send_word(row.req, row.pos, row.value);
      if (row.has_fixed && pending_resp[$] != row.fixed)
        report_mismatch($sformatf("table row %0d", i), to_word(pending_resp[$]),
                        to_word(row.fixed));
    end

    // fill to capacity while the receiver stalls, then probe the full case
    hold_off = 1'b1;
    while (shadow_list.size() < CAP)
      send_word(idxll_pkg::REQ_APPEND, 5'($urandom), $urandom);
    hold_off = 1'b0;
    send_word(idxll_pkg::REQ_APPEND, 5'd0, 32'h1);
    send_word(idxll_pkg::REQ_INSERT, 5'd31, 32'h1);
    send_word(idxll_pkg::REQ_INSERT, 5'd0, 32'h1);
    send_word(idxll_pkg::REQ_READ, 5'd31, 32'h0);
    send_word(idxll_pkg::REQ_REMOVE, 5'd31, 32'h0);

    repeat (N_RANDOM) send_random();
    stim_done = 1'b1;
  end

  // receiver: random stall per word, plus one long hold-off during the fill
  initial begin
    int stall_cycles;
    forever begin
      @(posedge clk_i);
      if (hold_off) begin
        m_axis_tready <= 1'b0;
        stall_cycles = 0;
        while (hold_off && stall_cycles < 400) begin
          @(posedge clk_i);
          stall_cycles++;
        end
      end
      stall_cycles = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 7);
      if (stall_cycles > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall_cycles - 1) @(posedge clk_i);
        @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      m_axis_tready <= 1'b0;
    end
  end

  // checker: compare each accepted output word against the oldest expectation
  always @(posedge clk_i) begin
    resp_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_resp.size() == 0)
        report_mismatch("unexpected word", m_axis_tdata, '0);
      else begin
        want = pending_resp.pop_front();
        if (m_axis_tdata[1:0] !== want.status)
          report_mismatch("status", m_axis_tdata, to_word(want));
        if (m_axis_tdata[33:2] !== want.data_out)
          report_mismatch("data_out", m_axis_tdata, to_word(want));
        if (m_axis_tdata[38:34] !== want.found_pos)
          report_mismatch("found_position", m_axis_tdata, to_word(want));
        if (m_axis_tdata[44:39] !== want.item_count)
          report_mismatch("item_count", m_axis_tdata, to_word(want));
      end
    end
  end

  // end of run: drain expectations, then allow for trailing latency
  initial begin
    wait (stim_done);
    while (pending_resp.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (err_count == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

  // watchdog
  initial begin
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
